[src/gbd_pkg.sv]
// Shared definitions for the graph bridge detector.
// Holds state codes, operation codes and configuration constants.
// No dependencies.
package gbd_pkg;

  localparam int DEF_MAX_NODES = 128;
  localparam int WORD_BITS     = 64;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int NODE_COUNT_W  = 8;
  localparam int NODE_FIELD_W  = 7;

  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 8'd128;
  localparam logic [CFG_ADDR_W-1:0]   ADDR_NODE_COUNT  = 3'd0;

  typedef enum logic {
    OP_ADD_EDGE = 1'b0,
    OP_EVALUATE = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_A,
    ST_EDGE_B,
    ST_ROOT_RD,
    ST_ROOT_WAIT,
    ST_SCAN_RD,
    ST_SCAN_WAIT,
    ST_SCAN_PICK,
    ST_VISIT,
    ST_POP_WAIT,
    ST_FIN,
    ST_SWEEP
  } state_t;

endpackage

[src/gbd_ram.sv]
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Depends on nothing; used for the adjacency matrix and the node records.
module gbd_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/gbd_walk.sv]
// Sequencer for edge loading, the depth-first walk and the clearing sweep.
// Uses gbd_pkg; drives the adjacency RAM and the node record RAM.
module gbd_walk
  import gbd_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  localparam int NW = $clog2(MAX_NODES),
  localparam int CW = $clog2(MAX_NODES + 1),
  localparam int WPR = (MAX_NODES + WORD_BITS - 1) / WORD_BITS,
  localparam int ADJ_DEPTH = MAX_NODES * WPR,
  localparam int AW = $clog2(ADJ_DEPTH),
  localparam int SW = $clog2(WPR * WORD_BITS + 1),
  localparam int REC_W = 1 + 3 * NW + SW
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_op,
  input  logic [NODE_FIELD_W-1:0] in_node_a,
  input  logic [NODE_FIELD_W-1:0] in_node_b,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_has_bridge,
  input  logic [CW-1:0]           node_limit,
  output logic                    adj_we,
  output logic [AW-1:0]           adj_waddr,
  output logic [WORD_BITS-1:0]    adj_wdata,
  output logic                    adj_re,
  output logic [AW-1:0]           adj_raddr,
  input  logic [WORD_BITS-1:0]    adj_rdata,
  output logic                    rec_we,
  output logic [NW-1:0]           rec_waddr,
  output logic [REC_W-1:0]        rec_wdata,
  output logic                    rec_re,
  output logic [NW-1:0]           rec_raddr,
  input  logic [REC_W-1:0]        rec_rdata
);

  localparam int WW = (WPR > 1) ? $clog2(WPR) : 1;
  // Record layout, most significant first: visited, depth, low, parent, scan.
  localparam int VIS_B = REC_W - 1;
  localparam int DEP_L = 2 * NW + SW;
  localparam int LOW_L = NW + SW;
  localparam int PAR_L = SW;

  state_t               state_r, state_nxt;
  logic [NODE_FIELD_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [NW-1:0]        cur_r, cur_nxt, par_r, par_nxt;
  logic [NW-1:0]        dep_r, dep_nxt, low_r, low_nxt;
  logic [SW-1:0]        scan_r, scan_nxt;
  logic [CW-1:0]        root_r, root_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic                 bridge_r, bridge_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hb_r, out_hb_nxt;
  logic [AW-1:0]        sweep_r, sweep_nxt;

  logic                 pick_found;
  logic [5:0]           pick_idx;
  logic [NW-1:0]        rd_dep, rd_low, rd_par;
  logic [SW-1:0]        rd_scan;
  logic                 rd_vis;

  function automatic logic [AW-1:0] adj_addr(input logic [NW-1:0] row,
                                             input logic [WW-1:0] word);
    adj_addr = AW'(int'(row) * WPR + int'(word));
  endfunction

  assign rd_vis  = rec_rdata[VIS_B];
  assign rd_dep  = rec_rdata[DEP_L +: NW];
  assign rd_low  = rec_rdata[LOW_L +: NW];
  assign rd_par  = rec_rdata[PAR_L +: NW];
  assign rd_scan = rec_rdata[SW-1:0];

  // Lowest set bit of the masked adjacency word.
  always_comb begin
    pick_found = 1'b0;
    pick_idx   = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (word_r[k]) begin
        pick_found = 1'b1;
        pick_idx   = 6'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
      bridge_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
      bridge_r    <= bridge_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    cur_r    <= cur_nxt;
    par_r    <= par_nxt;
    dep_r    <= dep_nxt;
    low_r    <= low_nxt;
    scan_r   <= scan_nxt;
    root_r   <= root_nxt;
    word_r   <= word_nxt;
    out_hb_r <= out_hb_nxt;
  end

  always_comb begin
    int            rem;
    int            sword;
    int            vnum;
    logic [63:0]   lo_mask;
    logic [63:0]   hi_mask;
    logic [NW-1:0] v;

    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    cur_nxt       = cur_r;
    par_nxt       = par_r;
    dep_nxt       = dep_r;
    low_nxt       = low_r;
    scan_nxt      = scan_r;
    root_nxt      = root_r;
    word_nxt      = word_r;
    bridge_nxt    = bridge_r;
    out_hb_nxt    = out_hb_r;
    sweep_nxt     = sweep_r;
    out_valid_nxt = out_valid_r && out_stall;

    adj_we    = 1'b0;
    adj_waddr = '0;
    adj_wdata = '0;
    adj_re    = 1'b0;
    adj_raddr = '0;
    rec_we    = 1'b0;
    rec_waddr = cur_r;
    rec_wdata = {1'b1, dep_r, low_r, par_r, scan_r};
    rec_re    = 1'b0;
    rec_raddr = '0;

    sword   = int'(scan_r) >> 6;
    rem     = int'(node_limit) - sword * WORD_BITS;
    lo_mask = ~((64'd1 << scan_r[5:0]) - 64'd1);
    hi_mask = (rem >= WORD_BITS) ? '1 : ((64'd1 << rem[5:0]) - 64'd1);
    vnum    = sword * WORD_BITS + int'(pick_idx);
    v       = NW'(vnum);

    in_stall = (state_r != ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          a_nxt = in_node_a;
          b_nxt = in_node_b;
          if (in_op == OP_EVALUATE) begin
            bridge_nxt = 1'b0;
            root_nxt   = '0;
            state_nxt  = ST_ROOT_RD;
          end else if (int'(in_node_a) < MAX_NODES && int'(in_node_b) < MAX_NODES &&
                       in_node_a != in_node_b) begin
            adj_re    = 1'b1;
            adj_raddr = adj_addr(NW'(in_node_a), WW'(in_node_b >> 6));
            state_nxt = ST_EDGE_A;
          end
        end
      end
      ST_EDGE_A: begin
        adj_we    = 1'b1;
        adj_waddr = adj_addr(NW'(a_r), WW'(b_r >> 6));
        adj_wdata = adj_rdata | (64'd1 << b_r[5:0]);
        adj_re    = 1'b1;
        adj_raddr = adj_addr(NW'(b_r), WW'(a_r >> 6));
        state_nxt = ST_EDGE_B;
      end
      ST_EDGE_B: begin
        adj_we    = 1'b1;
        adj_waddr = adj_addr(NW'(b_r), WW'(a_r >> 6));
        adj_wdata = adj_rdata | (64'd1 << a_r[5:0]);
        state_nxt = ST_IDLE;
      end
      ST_ROOT_RD: begin
        if (root_r >= node_limit) begin
          state_nxt = ST_FIN;
        end else begin
          rec_re    = 1'b1;
          rec_raddr = NW'(root_r);
          state_nxt = ST_ROOT_WAIT;
        end
      end
      ST_ROOT_WAIT: begin
        if (rd_vis) begin
          root_nxt  = root_r + 1'b1;
          state_nxt = ST_ROOT_RD;
        end else begin
          cur_nxt   = NW'(root_r);
          par_nxt   = NW'(root_r);
          dep_nxt   = '0;
          low_nxt   = '0;
          scan_nxt  = '0;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        // The current node's record is kept up to date in the RAM here.
        rec_we = 1'b1;
        if (int'(scan_r) >= int'(node_limit)) begin
          if (par_r == cur_r) begin
            root_nxt  = root_r + 1'b1;
            state_nxt = ST_ROOT_RD;
          end else begin
            rec_re    = 1'b1;
            rec_raddr = par_r;
            state_nxt = ST_POP_WAIT;
          end
        end else begin
          adj_re    = 1'b1;
          adj_raddr = adj_addr(cur_r, WW'(sword));
          state_nxt = ST_SCAN_WAIT;
        end
      end
      ST_SCAN_WAIT: begin
        word_nxt  = adj_rdata & lo_mask & hi_mask;
        state_nxt = ST_SCAN_PICK;
      end
      ST_SCAN_PICK: begin
        if (pick_found) begin
          scan_nxt  = SW'(vnum + 1);
          rec_re    = 1'b1;
          rec_raddr = v;
          a_nxt     = NODE_FIELD_W'(pick_idx);
          state_nxt = ST_VISIT;
        end else begin
          scan_nxt  = SW'((sword + 1) * WORD_BITS);
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_VISIT: begin
        // The neighbour is rebuilt from the scan position just advanced past it.
        v = NW'(int'(scan_r) - 1);
        if (!rd_vis) begin
          rec_we    = 1'b1;
          cur_nxt   = v;
          par_nxt   = cur_r;
          dep_nxt   = dep_r + 1'b1;
          low_nxt   = dep_r + 1'b1;
          scan_nxt  = '0;
        end else if (v != par_r && rd_dep < low_r) begin
          low_nxt = rd_dep;
        end
        state_nxt = ST_SCAN_RD;
      end
      ST_POP_WAIT: begin
        if (low_r > rd_dep) begin
          bridge_nxt = 1'b1;
        end
        low_nxt   = (low_r < rd_low) ? low_r : rd_low;
        cur_nxt   = par_r;
        par_nxt   = rd_par;
        dep_nxt   = rd_dep;
        scan_nxt  = rd_scan;
        state_nxt = ST_SCAN_RD;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_hb_nxt    = bridge_r;
          sweep_nxt     = '0;
          state_nxt     = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        adj_we    = 1'b1;
        adj_waddr = sweep_r;
        adj_wdata = '0;
        if (int'(sweep_r) < MAX_NODES) begin
          rec_we    = 1'b1;
          rec_waddr = NW'(sweep_r);
          rec_wdata = '0;
        end
        if (int'(sweep_r) == ADJ_DEPTH - 1) begin
          state_nxt = ST_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_has_bridge = out_hb_r;

  a_word_only_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result word raised outside the finishing step");

  a_pop_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POP_WAIT |-> $past(state_r) == ST_SCAN_RD)
    else $error("parent record used without a read from the scan step");

  a_edge_pair: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EDGE_B |-> $past(state_r) == ST_EDGE_A)
    else $error("second row update without the first");

  a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWEEP |-> int'(sweep_r) < ADJ_DEPTH)
    else $error("clearing sweep ran past the matrix");

endmodule

[src/graph_bridge_detector.sv]
// Graph bridge detector: loads edges into an adjacency matrix and reports
// whether the loaded graph has a bridge. Depends on gbd_pkg, gbd_ram, gbd_walk.
//
// Input channel (in_valid/in_stall): a word with in_op clear adds the
// undirected edge {in_node_a, in_node_b}; self-loops and endpoints at or above
// MAX_NODES are dropped. An edge is a read-modify-write of each endpoint's
// row in the single adjacency RAM. A word with in_op set runs a depth-first
// walk over nodes below node_count (register at byte address 0, saturated to
// MAX_NODES), gives one word on the output channel and clears the graph. The
// walk tries each root candidate, reads 64-bit row words, reads the row word
// again after each neighbour found and returns to each parent; then the
// matrix is swept clear, MAX_NODES*ceil(MAX_NODES/64) words (256 by default),
// during which no input word is taken. Edge words are taken while a result
// waits in the output register; an evaluation finishes its walk and then
// holds until the output register is free.
// Reset runs the same clearing sweep before the first input word is taken;
// node_count resets to 128. The user must write it over the APB port only
// while no evaluation is in progress, since the walk reads it throughout;
// the block itself does not enforce this.
module graph_bridge_detector
  import gbd_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_op,
  input  logic [NODE_FIELD_W-1:0] in_node_a,
  input  logic [NODE_FIELD_W-1:0] in_node_b,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_has_bridge,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [CFG_DATA_W-1:0]   cfg_prdata,
  output logic                    cfg_pready
);

  localparam int NW        = $clog2(MAX_NODES);
  localparam int CW        = $clog2(MAX_NODES + 1);
  localparam int WPR       = (MAX_NODES + WORD_BITS - 1) / WORD_BITS;
  localparam int ADJ_DEPTH = MAX_NODES * WPR;
  localparam int AW        = $clog2(ADJ_DEPTH);
  localparam int SW        = $clog2(WPR * WORD_BITS + 1);
  localparam int REC_W     = 1 + 3 * NW + SW;

  logic [NODE_COUNT_W-1:0] node_count_r, node_count_nxt;
  logic [CW-1:0]           node_limit;

  logic                 adj_we, adj_re;
  logic [AW-1:0]        adj_waddr, adj_raddr;
  logic [WORD_BITS-1:0] adj_wdata, adj_rdata;
  logic                 rec_we, rec_re;
  logic [NW-1:0]        rec_waddr, rec_raddr;
  logic [REC_W-1:0]     rec_wdata, rec_rdata;

  always_comb begin
    node_count_nxt = node_count_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_NODE_COUNT) begin
      node_count_nxt = cfg_pwdata[NODE_COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RESET;
    end else begin
      node_count_r <= node_count_nxt;
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_NODE_COUNT) ?
                      CFG_DATA_W'(node_count_r) : '0;
  assign node_limit = (int'(node_count_r) > MAX_NODES) ? CW'(MAX_NODES) :
                      CW'(node_count_r);

  gbd_ram #(
    .DEPTH(ADJ_DEPTH),
    .WIDTH(WORD_BITS)
  ) u_adj_ram (
    .clk  (clk),
    .we   (adj_we),
    .waddr(adj_waddr),
    .wdata(adj_wdata),
    .re   (adj_re),
    .raddr(adj_raddr),
    .rdata(adj_rdata)
  );

  gbd_ram #(
    .DEPTH(MAX_NODES),
    .WIDTH(REC_W)
  ) u_rec_ram (
    .clk  (clk),
    .we   (rec_we),
    .waddr(rec_waddr),
    .wdata(rec_wdata),
    .re   (rec_re),
    .raddr(rec_raddr),
    .rdata(rec_rdata)
  );

  gbd_walk #(
    .MAX_NODES(MAX_NODES)
  ) u_walk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_node_a     (in_node_a),
    .in_node_b     (in_node_b),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_has_bridge(out_has_bridge),
    .node_limit    (node_limit),
    .adj_we        (adj_we),
    .adj_waddr     (adj_waddr),
    .adj_wdata     (adj_wdata),
    .adj_re        (adj_re),
    .adj_raddr     (adj_raddr),
    .adj_rdata     (adj_rdata),
    .rec_we        (rec_we),
    .rec_waddr     (rec_waddr),
    .rec_wdata     (rec_wdata),
    .rec_re        (rec_re),
    .rec_raddr     (rec_raddr),
    .rec_rdata     (rec_rdata)
  );

endmodule
